// ----- rtl/cftb_pkg.sv -----
// Shared types and constants for the cron field to bit mask block.
package cftb_pkg;

    localparam int VALUE_W      = 64;
    localparam int MASK_BITS_DF = 64;
    localparam int CHAR_W       = 8;
    localparam int RANGE_W      = 6;
    localparam int CFG_IDX_W    = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_FIRST = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LAST  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_EMPTY  = 2'd2;

    localparam logic [RANGE_W-1:0] RANGE_FIRST_RST = 6'd0;
    localparam logic [RANGE_W-1:0] RANGE_LAST_RST  = 6'd59;

    typedef struct packed {
        logic take;    // apply accepted character to the part parser
        logic load;    // close the part: load sweep bounds, clear the part
        logic step;    // advance the sweep by the part's step increment
        logic emit;    // load output register, clear the accumulator
    } t_ctrl_cmd;

    typedef struct packed {
        logic is_comma;
        logic is_last;
        logic sweep_busy;
    } t_ctrl_stat;

endpackage

// ----- rtl/cftb_ctrl.sv -----
// Controller state machine sequencing parse, part close, sweep and result beat.
module cftb_ctrl
    import cftb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    input  t_ctrl_stat i_stat,
    output t_ctrl_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CLOSE,
        S_SWEEP,
        S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_last, n_last;
    logic   r_out_valid, n_out_valid;
    logic   in_acc;
    logic   out_free;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_last      = r_last;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    o_cmd.take = !i_stat.is_comma;
                    if (i_stat.is_comma || i_stat.is_last) begin
                        n_last  = i_stat.is_last;
                        n_state = S_CLOSE;
                    end
                end
            end
            S_CLOSE: begin
                o_cmd.load = 1'b1;
                n_state    = S_SWEEP;
            end
            S_SWEEP: begin
                o_cmd.step = 1'b1;
                if (!i_stat.sweep_busy) begin
                    n_state = r_last ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT: begin
                // hold until the previous beat has left the output register
                if (out_free) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ----- rtl/cftb_datapath.sv -----
// Datapath: configuration registers, part parser, sweep counter, mask and output register.
module cftb_datapath
    import cftb_pkg::*;
#(
    parameter int MASK_BITS = MASK_BITS_DF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [RANGE_W-1:0]   i_cfg_data,
    input  logic [CHAR_W-1:0]    i_char_code,
    input  logic                 i_end_of_text,
    input  t_ctrl_cmd            i_cmd,
    output t_ctrl_stat           o_stat,
    output logic [VALUE_W-1:0]   o_value_mask
);

    localparam int NUM_W = 7;
    localparam int POS_W = 8;
    localparam logic [NUM_W-1:0] NUM_MAX = 7'd127;

    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    localparam int HAVE_START = 0;
    localparam int HAVE_END   = 1;
    localparam int HAVE_STEP  = 2;

    typedef enum logic [2:0] {
        PH_START,
        PH_START_NUM,
        PH_END_NUM,
        PH_STEP_NUM,
        PH_IGNORE,
        PH_AFTER_STAR
    } t_phase;

    function automatic logic [NUM_W-1:0] add_digit(input logic [NUM_W-1:0] acc,
                                                   input logic [3:0] d);
        logic [10:0] v;
        begin
            v = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {7'd0, d};
            add_digit = (v > {4'd0, NUM_MAX}) ? NUM_MAX : v[NUM_W-1:0];
        end
    endfunction

    // configuration
    logic [RANGE_W-1:0] r_first, r_last;
    logic               r_fill;

    // part parser
    t_phase           r_phase, n_phase;
    logic [NUM_W-1:0] r_start, n_start;
    logic [NUM_W-1:0] r_end, n_end;
    logic [NUM_W-1:0] r_stepn, n_stepn;
    logic [2:0]       r_present, n_present;
    logic             r_star, n_star;

    // sweep
    logic               r_run, n_run;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [RANGE_W-1:0] r_to, n_to;
    logic [NUM_W-1:0]   r_inc, n_inc;

    logic [MASK_BITS-1:0] r_acc, n_acc;
    logic [VALUE_W-1:0]   r_value;
    logic [VALUE_W-1:0]   n_value;

    logic               digit;
    logic [3:0]         dval;
    logic               busy;
    logic [RANGE_W-1:0] k;
    logic [RANGE_W-1:0] span;
    logic [MASK_BITS-1:0] fill_mask;
    logic [NUM_W-1:0]   step_eff;
    logic               lone_ok;

    assign digit = (i_char_code >= CH_ZERO) && (i_char_code <= CH_NINE);
    assign dval  = 4'(i_char_code - CH_ZERO);
    assign busy  = r_run && (r_pos <= {2'b00, r_to});
    assign k     = r_pos[RANGE_W-1:0] - r_first;
    assign span  = r_last - r_first;

    assign step_eff = (r_present[HAVE_STEP] && (r_stepn != '0)) ? r_stepn : 7'd1;
    assign lone_ok  = (r_present == 3'b001) && ({1'b0, r_first} <= r_start)
                      && (r_start <= {1'b0, r_last});

    assign o_stat.is_comma   = (i_char_code == CH_COMMA);
    assign o_stat.is_last    = i_end_of_text;
    assign o_stat.sweep_busy = busy;
    assign o_value_mask      = r_value;

    always_comb begin
        for (int i = 0; i < MASK_BITS; i++) begin
            fill_mask[i] = (6'(i) <= span);
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_start   = r_start;
        n_end     = r_end;
        n_stepn   = r_stepn;
        n_present = r_present;
        n_star    = r_star;
        n_run     = r_run;
        n_pos     = r_pos;
        n_to      = r_to;
        n_inc     = r_inc;
        n_acc     = r_acc;
        n_value   = r_value;

        if (i_cmd.take) begin
            case (r_phase)
                PH_START: begin
                    if (i_char_code == CH_STAR) begin
                        n_star  = 1'b1;
                        n_phase = PH_AFTER_STAR;
                    end else if (digit) begin
                        n_start               = {3'd0, dval};
                        n_present[HAVE_START] = 1'b1;
                        n_phase               = PH_START_NUM;
                    end else if (i_char_code == CH_DASH) begin
                        n_phase = PH_END_NUM;
                    end else begin
                        n_phase = PH_IGNORE;
                    end
                end
                PH_START_NUM: begin
                    if (digit) begin
                        n_start = add_digit(r_start, dval);
                    end else begin
                        n_phase = (i_char_code == CH_DASH) ? PH_END_NUM : PH_IGNORE;
                    end
                end
                PH_END_NUM: begin
                    if (digit) begin
                        n_end = r_present[HAVE_END] ? add_digit(r_end, dval) : {3'd0, dval};
                        n_present[HAVE_END] = 1'b1;
                    end else begin
                        n_phase = (i_char_code == CH_SLASH) ? PH_STEP_NUM : PH_IGNORE;
                    end
                end
                PH_AFTER_STAR: begin
                    n_phase = (i_char_code == CH_SLASH) ? PH_STEP_NUM : PH_IGNORE;
                end
                PH_STEP_NUM: begin
                    if (digit) begin
                        n_stepn = r_present[HAVE_STEP] ? add_digit(r_stepn, dval)
                                                       : {3'd0, dval};
                        n_present[HAVE_STEP] = 1'b1;
                    end else begin
                        n_phase = PH_IGNORE;
                    end
                end
                default: begin
                    n_phase = PH_IGNORE;
                end
            endcase
        end

        if (i_cmd.load) begin
            // pick the sweep bounds for the part, then clear it
            if (r_star) begin
                n_run = 1'b1;
                n_pos = {2'b00, r_first};
                n_to  = r_last;
                n_inc = step_eff;
            end else if (r_present == 3'b001) begin
                n_run = lone_ok;
                n_pos = {1'b0, r_start};
                n_to  = r_start[RANGE_W-1:0];
                n_inc = 7'd1;
            end else if (r_present[HAVE_START] && r_present[HAVE_END]) begin
                n_run = 1'b1;
                n_pos = (r_start < {1'b0, r_first}) ? {2'b00, r_first} : {1'b0, r_start};
                n_to  = (r_end < {1'b0, r_last}) ? r_end[RANGE_W-1:0] : r_last;
                n_inc = step_eff;
            end else begin
                n_run = 1'b0;
            end
            n_phase   = PH_START;
            n_start   = '0;
            n_end     = '0;
            n_stepn   = '0;
            n_present = '0;
            n_star    = 1'b0;
        end

        if (i_cmd.step && busy) begin
            for (int i = 0; i < MASK_BITS; i++) begin
                if (k == 6'(i)) begin
                    n_acc[i] = 1'b1;
                end
            end
            n_pos = r_pos + {1'b0, r_inc};
        end

        if (i_cmd.emit) begin
            if ((r_acc == '0) && r_fill && (r_first <= r_last)) begin
                n_value = VALUE_W'(fill_mask);
            end else begin
                n_value = VALUE_W'(r_acc);
            end
            n_acc = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first   <= RANGE_FIRST_RST;
            r_last    <= RANGE_LAST_RST;
            r_fill    <= 1'b0;
            r_phase   <= PH_START;
            r_start   <= '0;
            r_end     <= '0;
            r_stepn   <= '0;
            r_present <= '0;
            r_star    <= 1'b0;
            r_run     <= 1'b0;
            r_pos     <= '0;
            r_to      <= '0;
            r_inc     <= 7'd1;
            r_acc     <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_RANGE_FIRST: r_first <= i_cfg_data;
                    CFG_RANGE_LAST:  r_last  <= i_cfg_data;
                    CFG_FILL_EMPTY:  r_fill  <= i_cfg_data[0];
                    default: begin
                        // drop writes to unused indexes
                    end
                endcase
            end
            r_phase   <= n_phase;
            r_start   <= n_start;
            r_end     <= n_end;
            r_stepn   <= n_stepn;
            r_present <= n_present;
            r_star    <= n_star;
            r_run     <= n_run;
            r_pos     <= n_pos;
            r_to      <= n_to;
            r_inc     <= n_inc;
            r_acc     <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

// ----- rtl/cron_field_to_bitmask.sv -----
// Top level of the cron field to bit mask block.
// Characters of one schedule field (parts such as N, A-B, A-B/S, *, */S,
// separated by commas) arrive one per input beat; the beat flagged
// end_of_text closes the field and yields one output beat holding the value
// mask, bit k standing for value range_first + k. A comma, or the final
// character, closes the current part: its bounds are loaded and the sweep
// counter visits the part's positions (at most 64), marking one mask bit per
// cycle, while the input stalls; the final character then loads the result.
// Configuration (range_first, range_last, fill_when_empty) is written through
// a plain write port; the user must write it only while the block is idle,
// as the block itself does not enforce this.
module cron_field_to_bitmask
    import cftb_pkg::*;
#(
    parameter int MASK_BITS = MASK_BITS_DF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [RANGE_W-1:0]   i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [CHAR_W-1:0]    i_char_code,
    input  logic                 i_end_of_text,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [VALUE_W-1:0]   o_value_mask
);

    t_ctrl_cmd  cmd;
    t_ctrl_stat stat;

    cftb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    cftb_datapath #(
        .MASK_BITS (MASK_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_char_code   (i_char_code),
        .i_end_of_text (i_end_of_text),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_value_mask  (o_value_mask)
    );

endmodule
